// ===== sv/byte_stuffed_frame_receiver_core_defines.svh =====
// assertion macros for the frame receiver rtl
`ifndef BYTE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define BFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bfr assertion failed");

`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfr implication failed");

`else

`define BFR_ASSERT(label, clk, rst_n, prop)

`define BFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/bfr_pkg.sv =====
// shared types, constants and crc step for the frame receiver
`default_nettype none

package bfr_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_XOR     = 8'h20;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd32764;

    typedef enum logic [1:0] {
        CLS_DATA = 2'd0,
        CLS_ESC  = 2'd1,
        CLS_FLAG = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_GOOD       = 3'd1,
        EV_DOUBLE_ESC = 3'd2,
        EV_ESC_FLAG   = 3'd3,
        EV_TOO_SHORT  = 3'd4,
        EV_TOO_LONG   = 3'd5,
        EV_CRC_BAD    = 3'd6
    } event_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] rx_byte;
    } item_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bfr_classify.sv =====
// front: accepts raw line bytes and tags them as flag, escape or data
`default_nettype none

module bfr_classify (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_rx_byte,
    output logic           push,
    output bfr_pkg::item_t push_item,
    input  logic           queue_full
);

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        push_item.rx_byte = s_rx_byte;
        case (s_rx_byte)
            bfr_pkg::FLAG_BYTE: push_item.cls = bfr_pkg::CLS_FLAG;
            bfr_pkg::ESC_BYTE:  push_item.cls = bfr_pkg::CLS_ESC;
            default:            push_item.cls = bfr_pkg::CLS_DATA;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bfr_queue.sv =====
// two-entry queue between the classifier and the frame engine
`default_nettype none

module bfr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bfr_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output bfr_pkg::item_t pop_item
);

    bfr_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bfr_engine.sv =====
// back: unstuffing, hold-back, running crc, verdicts and the result register
`default_nettype none
`include "byte_stuffed_frame_receiver_core_defines.svh"

module bfr_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  bfr_pkg::item_t in_item,
    output logic           pop,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_frame_event,
    output logic [15:0]    m_payload_length,
    output logic           m_data_valid,
    output logic [7:0]     m_data_byte
);

    logic [15:0]      max_payload_reg;
    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [16:0]      count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       hold0_reg, hold0_next;
    logic [7:0]       hold1_reg, hold1_next;

    logic             m_valid_reg, m_valid_next;
    bfr_pkg::event_t  ev_reg, ev_next;
    logic [15:0]      len_reg, len_next;
    logic             dv_reg, dv_next;
    logic [7:0]       db_reg, db_next;

    logic [7:0]       unesc;
    logic [16:0]      count_less2;
    logic [15:0]      plen;

    assign cfg_ready        = 1'b1;
    assign pop              = in_valid && (!m_valid_reg || m_ready);
    assign m_valid          = m_valid_reg;
    assign m_frame_event    = ev_reg;
    assign m_payload_length = len_reg;
    assign m_data_valid     = dv_reg;
    assign m_data_byte      = db_reg;

    assign unesc       = esc_reg ? (in_item.rx_byte ^ bfr_pkg::ESC_XOR) : in_item.rx_byte;
    assign count_less2 = count_reg - 17'd2;

    always_comb begin
        if (count_reg < 17'd2) begin
            plen = 16'd0;
        end else if (count_less2[16]) begin
            plen = 16'hFFFF;
        end else begin
            plen = count_less2[15:0];
        end
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        ev_next       = bfr_pkg::EV_NONE;
        len_next      = 16'd0;
        dv_next       = 1'b0;
        db_next       = 8'd0;
        if (!in_frame_reg) begin
            if (in_item.cls == bfr_pkg::CLS_FLAG) begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = 17'd0;
                crc_next      = bfr_pkg::CRC_INIT;
            end
        end else begin
            case (in_item.cls)
                bfr_pkg::CLS_ESC: begin
                    if (!esc_reg) begin
                        esc_next = 1'b1;
                    end else begin
                        ev_next       = bfr_pkg::EV_DOUBLE_ESC;
                        len_next      = plen;
                        in_frame_next = 1'b0;
                        esc_next      = 1'b0;
                    end
                end
                bfr_pkg::CLS_DATA: begin
                    esc_next = 1'b0;
                    if (count_reg >= 17'd2) begin
                        dv_next    = 1'b1;
                        db_next    = hold0_reg;
                        crc_next   = bfr_pkg::crc_step(crc_reg, hold0_reg);
                        hold0_next = hold1_reg;
                        hold1_next = unesc;
                    end else if (!count_reg[0]) begin
                        hold0_next = unesc;
                    end else begin
                        hold1_next = unesc;
                    end
                    if (count_reg != bfr_pkg::COUNT_MAX) begin
                        count_next = count_reg + 17'd1;
                    end
                end
                bfr_pkg::CLS_FLAG: begin
                    len_next = plen;
                    if (esc_reg) begin
                        ev_next = bfr_pkg::EV_ESC_FLAG;
                    end else if (count_reg < 17'd2) begin
                        ev_next = bfr_pkg::EV_TOO_SHORT;
                    end else if (count_less2 > {1'b0, max_payload_reg}) begin
                        ev_next = bfr_pkg::EV_TOO_LONG;
                    end else if ({hold1_reg, hold0_reg} == crc_reg) begin
                        ev_next = bfr_pkg::EV_GOOD;
                    end else begin
                        ev_next = bfr_pkg::EV_CRC_BAD;
                    end
                    in_frame_next = (ev_next != bfr_pkg::EV_GOOD);
                    esc_next      = 1'b0;
                    count_next    = 17'd0;
                    crc_next      = bfr_pkg::CRC_INIT;
                end
                default: begin
                    esc_next = esc_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
            len_reg   <= len_next;
            dv_reg    <= dv_next;
            db_reg    <= db_next;
        end
        if (!aresetn) begin
            max_payload_reg <= bfr_pkg::MAX_PAYLOAD_RESET;
            in_frame_reg    <= 1'b0;
            esc_reg         <= 1'b0;
            count_reg       <= 17'd0;
            crc_reg         <= bfr_pkg::CRC_INIT;
            m_valid_reg     <= 1'b0;
            ev_reg          <= bfr_pkg::EV_NONE;
        end else begin
            if (cfg_valid) begin
                max_payload_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
            if (pop) begin
                in_frame_reg <= in_frame_next;
                esc_reg      <= esc_next;
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                ev_reg       <= ev_next;
            end
        end
    end

    `BFR_ASSERT_IMPL(a_esc_in_frame, aclk, aresetn, esc_reg, in_frame_reg)
    `BFR_ASSERT_IMPL(a_data_no_event, aclk, aresetn, m_valid_reg && dv_reg,
                     ev_reg == bfr_pkg::EV_NONE)
    `BFR_ASSERT(a_good_hunts, aclk, aresetn,
                (pop && ev_next == bfr_pkg::EV_GOOD) |=> (!in_frame_reg && count_reg == 17'd0))
    `BFR_ASSERT(a_short_len, aclk, aresetn,
                (m_valid_reg && ev_reg == bfr_pkg::EV_TOO_SHORT) |-> (len_reg == 16'd0))

endmodule

`default_nettype wire

// ===== sv/byte_stuffed_frame_receiver_core.sv =====
// top level of the byte-stuffed frame receiver with crc-16 check
//
//   channel  direction  ports                                         beat
//   s_       in         s_valid s_ready s_rx_byte                     one raw line byte
//   m_       out        m_valid m_ready m_frame_event m_payload_length
//                       m_data_valid m_data_byte                      one result per s_ beat
//   cfg_     in         cfg_valid cfg_ready cfg_data                  max_payload write
//
// one beat per cycle while m_ready is high; each beat is queued, its result registered
// the crc step over one hold-back byte is done combinationally in the engine
// a two-entry queue lets the classifier take beats while m_ready is low, until it is full
// synchronous active-low reset clears control state; max_payload resets to 32764
// cfg_ready is always high
`default_nettype none

module byte_stuffed_frame_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_frame_event,
    output logic [15:0] m_payload_length,
    output logic        m_data_valid,
    output logic [7:0]  m_data_byte
);

    logic           push;
    bfr_pkg::item_t push_item;
    logic           queue_full;
    logic           pop;
    logic           pop_valid;
    bfr_pkg::item_t pop_item;

    bfr_classify u_classify (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    bfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    bfr_engine u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (pop_valid),
        .in_item          (pop_item),
        .pop              (pop),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_event    (m_frame_event),
        .m_payload_length (m_payload_length),
        .m_data_valid     (m_data_valid),
        .m_data_byte      (m_data_byte)
    );

endmodule

`default_nettype wire

// ===== dv/byte_stuffed_frame_receiver_core_tb.sv =====
// testbench for the byte-stuffed frame receiver: framed byte stream in, per-byte verdicts checked
module byte_stuffed_frame_receiver_core_tb;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        bfr_pkg::event_t ev;
        logic [15:0]     len;
        logic            dv;
        logic [7:0]      db;
    } rx_result_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_DOUBLE_ESC,
        FLAW_ESC_AT_FLAG
    } frame_flaw_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_frame_event;
    logic [15:0] m_payload_length;
    logic        m_data_valid;
    logic [7:0]  m_data_byte;

    byte_stuffed_frame_receiver_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_event    (m_frame_event),
        .m_payload_length (m_payload_length),
        .m_data_valid     (m_data_valid),
        .m_data_byte      (m_data_byte)
    );

    // receiver state as predicted
    logic        frame_open = 1'b0;
    logic        esc_armed = 1'b0;
    logic [16:0] unesc_count = 17'd0;
    logic [15:0] crc_acc = bfr_pkg::CRC_INIT;
    logic [7:0]  held [2] = '{8'd0, 8'd0};
    logic [15:0] payload_limit = bfr_pkg::MAX_PAYLOAD_RESET;

    logic [7:0]  line_bytes_q [$];
    rx_result_t  rx_result_q [$];
    int          bytes_queued = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          verdict_count [7] = '{default: 0};
    int          quiet_cycles = 0;
    int          s_gap = 0;
    int          m_stall = 0;
    bit          idle_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_modbus_fold(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[k]) c = (c >> 1) ^ bfr_pkg::CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] counted_payload();
        logic [16:0] p;
        if (unesc_count < 17'd2) return 16'd0;
        p = unesc_count - 17'd2;
        return (p > 17'h0FFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void start_frame();
        frame_open = 1'b1;
        esc_armed = 1'b0;
        unesc_count = 17'd0;
        crc_acc = bfr_pkg::CRC_INIT;
    endfunction

    function automatic rx_result_t receive_byte(input logic [7:0] b);
        rx_result_t r;
        logic [7:0] d;
        r = '0;
        r.ev = bfr_pkg::EV_NONE;
        if (!frame_open) begin
            if (b == bfr_pkg::FLAG_BYTE) start_frame();
        end else if (b == bfr_pkg::ESC_BYTE) begin
            if (!esc_armed) begin
                esc_armed = 1'b1;
            end else begin
                r.ev = bfr_pkg::EV_DOUBLE_ESC;
                r.len = counted_payload();
                frame_open = 1'b0;
                esc_armed = 1'b0;
            end
        end else if (b != bfr_pkg::FLAG_BYTE) begin
            d = esc_armed ? (b ^ bfr_pkg::ESC_XOR) : b;
            esc_armed = 1'b0;
            if (unesc_count >= 17'd2) begin
                r.dv = 1'b1;
                r.db = held[0];
                crc_acc = crc16_modbus_fold(crc_acc, held[0]);
                held[0] = held[1];
                held[1] = d;
            end else begin
                held[unesc_count[0]] = d;
            end
            if (unesc_count != bfr_pkg::COUNT_MAX) unesc_count = unesc_count + 17'd1;
        end else begin
            r.len = counted_payload();
            if (esc_armed) r.ev = bfr_pkg::EV_ESC_FLAG;
            else if (unesc_count < 17'd2) r.ev = bfr_pkg::EV_TOO_SHORT;
            else if (unesc_count - 17'd2 > {1'b0, payload_limit}) r.ev = bfr_pkg::EV_TOO_LONG;
            else if ({held[1], held[0]} == crc_acc) r.ev = bfr_pkg::EV_GOOD;
            else r.ev = bfr_pkg::EV_CRC_BAD;
            if (r.ev == bfr_pkg::EV_GOOD) begin
                frame_open = 1'b0;
                esc_armed = 1'b0;
                unesc_count = 17'd0;
                crc_acc = bfr_pkg::CRC_INIT;
            end else begin
                start_frame();
            end
        end
        if (r.ev != bfr_pkg::EV_NONE) verdict_count[r.ev]++;
        return r;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_rx_byte <= 8'd0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) rx_result_q.push_back(receive_byte(s_rx_byte));
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (line_bytes_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= line_bytes_q.pop_front();
                    if (idle_on && $urandom_range(0, 9) == 0) s_gap = $urandom_range(1, 3);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        rx_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (rx_result_q.size() == 0) begin
                    note_error($sformatf("result with nothing expected: ev=%0d len=%0d dv=%0b db=%02h",
                        m_frame_event, m_payload_length, m_data_valid, m_data_byte));
                end else begin
                    want = rx_result_q.pop_front();
                    if (m_frame_event !== want.ev || m_payload_length !== want.len ||
                        m_data_valid !== want.dv || m_data_byte !== want.db)
                        note_error($sformatf({"result %0d mismatch: exp ev=%0d len=%0d dv=%0b ",
                            "db=%02h, got ev=%0d len=%0d dv=%0b db=%02h"}, results_seen,
                            want.ev, want.len, want.dv, want.db, m_frame_event,
                            m_payload_length, m_data_valid, m_data_byte));
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) m_stall = $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready) || results_seen == bytes_queued)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic void queue_byte(input logic [7:0] b);
        line_bytes_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(0, 7))
            0: return bfr_pkg::FLAG_BYTE;
            1: return bfr_pkg::ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_frame(input int plen, input frame_flaw_t flaw);
        logic [7:0]  body [$];
        logic [15:0] c;
        logic [7:0]  v;
        int          cut;
        c = bfr_pkg::CRC_INIT;
        for (int i = 0; i < plen; i++) begin
            v = pick_payload_byte();
            body.push_back(v);
            c = crc16_modbus_fold(c, v);
        end
        if (flaw == FLAW_CRC) c = c ^ (16'd1 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        cut = (flaw == FLAW_DOUBLE_ESC) ? $urandom_range(0, body.size() - 1) : -1;
        queue_byte(bfr_pkg::FLAG_BYTE);
        foreach (body[i]) begin
            if (i == cut) begin
                queue_byte(bfr_pkg::ESC_BYTE);
                queue_byte(bfr_pkg::ESC_BYTE);
            end
            // stuff the reserved bytes, and now and then an ordinary one
            if (body[i] == bfr_pkg::FLAG_BYTE || body[i] == bfr_pkg::ESC_BYTE ||
                ($urandom_range(0, 15) == 0 &&
                 (body[i] ^ bfr_pkg::ESC_XOR) != bfr_pkg::FLAG_BYTE &&
                 (body[i] ^ bfr_pkg::ESC_XOR) != bfr_pkg::ESC_BYTE)) begin
                queue_byte(bfr_pkg::ESC_BYTE);
                queue_byte(body[i] ^ bfr_pkg::ESC_XOR);
            end else begin
                queue_byte(body[i]);
            end
        end
        if (flaw == FLAW_ESC_AT_FLAG) queue_byte(bfr_pkg::ESC_BYTE);
        queue_byte(bfr_pkg::FLAG_BYTE);
    endtask

    task automatic run_random(input int n);
        int start;
        int ignored;
        int k;
        int plen;
        int m;
        start = bytes_queued;
        ignored = 0;
        while (bytes_queued - start - ignored < n) begin
            k = $urandom_range(0, 99);
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (k < 55) begin
                push_frame(plen, FLAW_NONE);
            end else if (k < 67) begin
                push_frame(plen, FLAW_CRC);
            end else if (k < 75) begin
                push_frame(plen, FLAW_DOUBLE_ESC);
            end else if (k < 82) begin
                push_frame(plen, FLAW_ESC_AT_FLAG);
            end else if (k < 90) begin
                queue_byte(bfr_pkg::FLAG_BYTE);
                if (k[0]) queue_byte(8'($urandom_range(0, 8'h7C)));
                queue_byte(bfr_pkg::FLAG_BYTE);
            end else begin
                m = $urandom_range(1, 6);
                ignored += m;
                repeat (m) queue_byte(8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (results_seen != bytes_queued) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        payload_limit = v;
    endtask

    initial begin : stimulus
        logic [7:0] opening [] = '{
            8'h00, 8'hFF, bfr_pkg::ESC_BYTE, 8'h5E,
            bfr_pkg::FLAG_BYTE, bfr_pkg::FLAG_BYTE, 8'h41, bfr_pkg::FLAG_BYTE,
            bfr_pkg::ESC_BYTE, bfr_pkg::ESC_BYTE,
            bfr_pkg::FLAG_BYTE, bfr_pkg::ESC_BYTE, bfr_pkg::FLAG_BYTE,
            8'hFF, 8'hFF, bfr_pkg::FLAG_BYTE,
            bfr_pkg::FLAG_BYTE, 8'h01, 8'h00, 8'h00, bfr_pkg::FLAG_BYTE,
            bfr_pkg::ESC_BYTE, 8'h5E, bfr_pkg::FLAG_BYTE};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit in force
        foreach (opening[i]) queue_byte(opening[i]);
        run_random(250);
        wait_drained();

        write_limit(16'd0);
        run_random(150);
        wait_drained();

        write_limit(16'd5);
        run_random(150);
        wait_drained();

        write_limit(16'($urandom_range(0, 15)));
        run_random(150);
        wait_drained();

        // no idling from here on
        idle_on = 1'b0;
        write_limit(16'hFFFF);
        run_random(150);
        wait_drained();
        repeat (10) @(posedge aclk);

        if (rx_result_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", rx_result_q.size()));

        $display("%0d line bytes sent, %0d results checked, %0d mismatches",
            bytes_queued, results_seen, errors);
        $display("verdicts: good %0d, double esc %0d, esc at flag %0d, short %0d, long %0d, crc %0d",
            verdict_count[bfr_pkg::EV_GOOD], verdict_count[bfr_pkg::EV_DOUBLE_ESC],
            verdict_count[bfr_pkg::EV_ESC_FLAG], verdict_count[bfr_pkg::EV_TOO_SHORT],
            verdict_count[bfr_pkg::EV_TOO_LONG], verdict_count[bfr_pkg::EV_CRC_BAD]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
